FILE: design/wgc_pkg.sv
// wgc_pkg: shared types, constants and tables for the waypoint go-to-goal controller
// used by wgc_solver and waypoint_go_to_goal_controller; no dependencies
package wgc_pkg;

	localparam int MAX_WAYPOINTS_DEF = 16;

	localparam int CORDIC_STEPS = 20;
	localparam int SQRT_STEPS   = 25;

	localparam logic signed [17:0] PI_Q12_W     = 18'sd12868;
	localparam logic signed [17:0] TWO_PI_Q12_W = 18'sd25736;
	localparam logic signed [23:0] PI_Q20_W     = 24'sd3294199;

	// command kinds
	localparam logic [1:0] KIND_NONE      = 2'd0;
	localparam logic [1:0] KIND_ROTATE    = 2'd1;
	localparam logic [1:0] KIND_TRANSLATE = 2'd2;
	localparam logic [1:0] KIND_STOP      = 2'd3;

	// item actions
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	// register indexes
	localparam logic [2:0] REG_COUNT    = 3'd0;
	localparam logic [2:0] REG_HEAD_TOL = 3'd1;
	localparam logic [2:0] REG_DIST_TOL = 3'd2;
	localparam logic [2:0] REG_HEAD_GN  = 3'd3;
	localparam logic [2:0] REG_SPEED_GN = 3'd4;
	localparam logic [2:0] REG_MAX_SPD  = 3'd5;
	localparam logic [2:0] REG_MAX_ROT  = 3'd6;

	// register reset values
	localparam logic [4:0]  RST_COUNT    = 5'd0;
	localparam logic [14:0] RST_HEAD_TOL = 15'd369;
	localparam logic [15:0] RST_DIST_TOL = 16'd655;
	localparam logic [9:0]  RST_HEAD_GN  = 10'd179;
	localparam logic [15:0] RST_SPEED_GN = 16'd1200;
	localparam logic [9:0]  RST_MAX_SPD  = 10'd500;
	localparam logic [14:0] RST_MAX_ROT  = 15'd25736;

	typedef logic signed [23:0] angle_q20_t;

	// arctan(2^-i) in rad * 2^20
	function automatic angle_q20_t atan_q20(input logic [4:0] i);
		angle_q20_t a;
		begin
			case (i)
				5'd0:  a = 24'sd823550;
				5'd1:  a = 24'sd486170;
				5'd2:  a = 24'sd256879;
				5'd3:  a = 24'sd130396;
				5'd4:  a = 24'sd65451;
				5'd5:  a = 24'sd32757;
				5'd6:  a = 24'sd16383;
				5'd7:  a = 24'sd8192;
				5'd8:  a = 24'sd4096;
				5'd9:  a = 24'sd2048;
				5'd10: a = 24'sd1024;
				5'd11: a = 24'sd512;
				5'd12: a = 24'sd256;
				5'd13: a = 24'sd128;
				5'd14: a = 24'sd64;
				5'd15: a = 24'sd32;
				5'd16: a = 24'sd16;
				5'd17: a = 24'sd8;
				5'd18: a = 24'sd4;
				5'd19: a = 24'sd2;
				default: a = 24'sd0;
			endcase
			return a;
		end
	endfunction

endpackage

FILE: design/waypoint_go_to_goal_controller.sv
// waypoint go-to-goal controller: waypoint table in a synchronous memory, a pose
// sample gives one motion command; a load item writes the table. A load, an
// advance tick or a tick after the route is done goes straight to the result
// stage; a pose sample that steers first waits for the 25-step bit-serial square
// root (the 20-step CORDIC runs beside it). One request is in work at a time; a
// new one is taken while the previous result waits at the output.
// depends on wgc_pkg and wgc_solver
module waypoint_go_to_goal_controller import wgc_pkg::*; #(
	parameter int MAX_WAYPOINTS = MAX_WAYPOINTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                action,
	input  logic [3:0]          waypoint_slot,
	input  logic signed [23:0]  waypoint_x,
	input  logic signed [23:0]  waypoint_y,
	input  logic signed [23:0]  pose_x,
	input  logic signed [23:0]  pose_y,
	input  logic signed [15:0]  pose_heading,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          command_kind,
	output logic signed [15:0]  command_value,
	output logic signed [15:0]  heading_error,
	output logic [24:0]         distance_error,
	output logic [4:0]          waypoint_index,
	output logic                route_done,
	output logic                map_enable,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data
);

	localparam int AW = $clog2(MAX_WAYPOINTS);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DIFF  = 3'd1;
	localparam logic [2:0] ST_SOLVE = 3'd2;
	localparam logic [2:0] ST_MUL   = 3'd3;
	localparam logic [2:0] ST_DEC   = 3'd4;
	localparam logic [2:0] ST_EMIT  = 3'd5;

	logic [2:0] state_q;

	logic [4:0]  count_q;
	logic [14:0] head_tol_q;
	logic [15:0] dist_tol_q;
	logic [9:0]  head_gn_q;
	logic [15:0] speed_gn_q;
	logic [9:0]  max_spd_q;
	logic [14:0] max_rot_q;

	logic [4:0] idx_q;
	logic       reached_q;
	logic       map_q;

	logic [47:0] wp_mem [MAX_WAYPOINTS];
	logic [47:0] rd_q;

	logic signed [23:0] px_q, py_q;
	logic signed [15:0] ph_q;
	logic [1:0]         kind_q;
	logic signed [15:0] value_q;
	logic signed [15:0] err_q;
	logic [24:0]        dist_q;
	logic signed [26:0] rot_prod_q;
	logic [40:0]        tr_prod_q;

	logic               in_acc, slot_ok, emit_go;
	logic [4:0]         act_cnt;
	logic signed [24:0] dx, dy;
	logic               sv_start, sv_done;
	logic [24:0]        sv_dist;
	logic signed [15:0] sv_bearing;
	logic signed [17:0] err0, err_w, c_m2, c_m1, c_p1, c_p2;
	logic [14:0]        aerr;
	logic signed [18:0] rot_rnd;
	logic signed [18:0] rot_lim;
	logic signed [15:0] rot_sat;
	logic [24:0]        sp;
	logic [15:0]        sp_sat;
	logic               far;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign slot_ok   = 32'(waypoint_slot) < MAX_WAYPOINTS;
	assign act_cnt   = (32'(count_q) > MAX_WAYPOINTS) ? 5'(MAX_WAYPOINTS) : count_q;
	assign emit_go   = (state_q == ST_EMIT) && (!out_valid || out_ready);

	// table: written by load requests, read at the current index
	always_ff @(posedge clk) begin
		if (in_acc && action == ACT_LOAD && slot_ok)
			wp_mem[AW'(waypoint_slot)] <= {waypoint_y, waypoint_x};
		rd_q <= wp_mem[AW'(idx_q)];
	end

	assign dx       = 25'(signed'(rd_q[23:0])) - 25'(px_q);
	assign dy       = 25'(signed'(rd_q[47:24])) - 25'(py_q);
	assign sv_start = (state_q == ST_DIFF);

	wgc_solver u_solver (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sv_start),
		.dx       (dx),
		.dy       (dy),
		.done     (sv_done),
		.distance (sv_dist),
		.bearing  (sv_bearing)
	);

	// wrap to (-pi, pi]; at most two turns either way
	assign err0 = 18'(sv_bearing) - 18'(ph_q);
	assign c_m2 = err0 - (TWO_PI_Q12_W <<< 1);
	assign c_m1 = err0 - TWO_PI_Q12_W;
	assign c_p1 = err0 + TWO_PI_Q12_W;
	assign c_p2 = err0 + (TWO_PI_Q12_W <<< 1);
	always_comb begin
		if (err0 > PI_Q12_W) begin
			err_w = (c_m1 > PI_Q12_W) ? c_m2 : c_m1;
		end else if (err0 <= -PI_Q12_W) begin
			err_w = (c_p1 <= -PI_Q12_W) ? c_p2 : c_p1;
		end else begin
			err_w = err0;
		end
	end

	assign aerr    = (err_q < 0) ? 15'(-err_q) : 15'(err_q);
	assign far     = dist_q > 25'(dist_tol_q);
	assign rot_rnd = 19'((rot_prod_q + 27'sd128) >>> 8);
	assign rot_lim = signed'({4'b0000, max_rot_q});
	always_comb begin
		if (rot_rnd > rot_lim)
			rot_sat = 16'(rot_lim);
		else if (rot_rnd < -rot_lim)
			rot_sat = 16'(-rot_lim);
		else
			rot_sat = 16'(rot_rnd);
	end
	assign sp     = tr_prod_q[40:16];
	assign sp_sat = (sp > 25'(max_spd_q)) ? 16'(max_spd_q) : 16'(sp);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= RST_COUNT;
			head_tol_q <= RST_HEAD_TOL;
			dist_tol_q <= RST_DIST_TOL;
			head_gn_q  <= RST_HEAD_GN;
			speed_gn_q <= RST_SPEED_GN;
			max_spd_q  <= RST_MAX_SPD;
			max_rot_q  <= RST_MAX_ROT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_COUNT:    count_q    <= cfg_data[4:0];
				REG_HEAD_TOL: head_tol_q <= cfg_data[14:0];
				REG_DIST_TOL: dist_tol_q <= cfg_data;
				REG_HEAD_GN:  head_gn_q  <= cfg_data[9:0];
				REG_SPEED_GN: speed_gn_q <= cfg_data;
				REG_MAX_SPD:  max_spd_q  <= cfg_data[9:0];
				REG_MAX_ROT:  max_rot_q  <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_q     <= '0;
			reached_q <= 1'b0;
			map_q     <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready && !emit_go)
				out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (action == ACT_TICK && idx_q < act_cnt && !reached_q)
							state_q <= ST_DIFF;
						else
							state_q <= ST_EMIT;
						if (action == ACT_TICK && idx_q < act_cnt && reached_q) begin
							idx_q     <= idx_q + 5'd1;
							reached_q <= 1'b0;
						end
					end
				end
				ST_DIFF:  state_q <= ST_SOLVE;
				ST_SOLVE: if (sv_done) state_q <= ST_MUL;
				ST_MUL:   state_q <= ST_DEC;
				ST_DEC: begin
					state_q <= ST_EMIT;
					if (aerr > head_tol_q && far) begin
						map_q <= 1'b0;
					end else if (far) begin
						map_q <= 1'b1;
					end else begin
						map_q     <= 1'b0;
						reached_q <= 1'b1;
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						state_q   <= ST_IDLE;
						out_valid <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			px_q    <= pose_x;
			py_q    <= pose_y;
			ph_q    <= pose_heading;
			kind_q  <= KIND_NONE;
			value_q <= '0;
			err_q   <= '0;
			dist_q  <= '0;
		end
		if (state_q == ST_SOLVE && sv_done) begin
			err_q  <= 16'(err_w);
			dist_q <= sv_dist;
		end
		if (state_q == ST_MUL) begin
			rot_prod_q <= 27'(err_q * signed'({1'b0, head_gn_q}));
			tr_prod_q  <= 41'(speed_gn_q * dist_q);
		end
		if (state_q == ST_DEC) begin
			if (aerr > head_tol_q && far) begin
				kind_q  <= KIND_ROTATE;
				value_q <= rot_sat;
			end else if (far) begin
				kind_q  <= KIND_TRANSLATE;
				value_q <= sp_sat;
			end else begin
				kind_q  <= KIND_STOP;
				value_q <= '0;
			end
		end
		if (emit_go) begin
			command_kind   <= kind_q;
			command_value  <= value_q;
			heading_error  <= err_q;
			distance_error <= dist_q;
			waypoint_index <= idx_q;
			route_done     <= idx_q >= act_cnt;
			map_enable     <= map_q;
		end
	end

	a_rot_no_map: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && command_kind == KIND_ROTATE |-> !map_enable)
		else $error("rotate result with mapping enabled");

	a_trans_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && command_kind == KIND_TRANSLATE |-> map_enable && !route_done)
		else $error("translate result inconsistent with route state");

	a_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (command_kind == KIND_NONE || command_kind == KIND_STOP)
		|-> command_value == 16'sd0)
		else $error("none or stop result with nonzero value");

	a_solver_done: assert property (@(posedge clk) disable iff (!arst_n)
		sv_done |-> state_q == ST_SOLVE)
		else $error("solver finished outside solve state");

endmodule

FILE: design/wgc_solver.sv
// wgc_solver: iterative distance (bit-serial square root) and bearing (CORDIC vectoring)
// depends on wgc_pkg
module wgc_solver import wgc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [24:0]  dx,
	input  logic signed [24:0]  dy,
	output logic                done,
	output logic [24:0]         distance,
	output logic signed [15:0]  bearing
);

	localparam logic [1:0] P_IDLE = 2'd0;
	localparam logic [1:0] P_SQ   = 2'd1;
	localparam logic [1:0] P_SUM  = 2'd2;
	localparam logic [1:0] P_RUN  = 2'd3;

	logic [1:0]         phase_q;
	logic [4:0]         cnt_q;
	logic               done_q;
	logic signed [24:0] dx_q, dy_q;
	logic [49:0]        sqx_q, sqy_q, n_q;
	logic [27:0]        rem_q;
	logic [24:0]        root_q;
	logic signed [43:0] cx_q, cy_q;
	angle_q20_t         cz_q;
	logic               zero_q;

	logic signed [43:0] x_init, y_init;
	angle_q20_t         z_init;
	logic [27:0]        rem_sh, trial;
	logic signed [43:0] xs, ys;
	logic signed [23:0] z_rnd;

	always_comb begin
		if (dx < 0) begin
			x_init = 44'(-dx) <<< 16;
			y_init = 44'(-dy) <<< 16;
			z_init = (dy >= 0) ? PI_Q20_W : -PI_Q20_W;
		end else begin
			x_init = 44'(dx) <<< 16;
			y_init = 44'(dy) <<< 16;
			z_init = '0;
		end
	end

	assign rem_sh = {rem_q[25:0], n_q[49:48]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign xs     = cx_q >>> cnt_q;
	assign ys     = cy_q >>> cnt_q;
	assign z_rnd  = cz_q + 24'sd128;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (phase_q == P_RUN) && (cnt_q == 5'(SQRT_STEPS - 1));
			unique case (phase_q)
				P_IDLE: if (start) phase_q <= P_SQ;
				P_SQ:   phase_q <= P_SUM;
				P_SUM: begin
					phase_q <= P_RUN;
					cnt_q   <= '0;
				end
				P_RUN: begin
					if (cnt_q == 5'(SQRT_STEPS - 1))
						phase_q <= P_IDLE;
					cnt_q <= cnt_q + 5'd1;
				end
				default: phase_q <= P_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (phase_q == P_IDLE && start) begin
			dx_q   <= dx;
			dy_q   <= dy;
			cx_q   <= x_init;
			cy_q   <= y_init;
			cz_q   <= z_init;
			zero_q <= (dx == 0) && (dy == 0);
		end
		if (phase_q == P_SQ) begin
			sqx_q <= 50'(dx_q * dx_q);
			sqy_q <= 50'(dy_q * dy_q);
		end
		if (phase_q == P_SUM) begin
			n_q    <= sqx_q + sqy_q;
			rem_q  <= '0;
			root_q <= '0;
		end
		if (phase_q == P_RUN) begin
			n_q <= {n_q[47:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[23:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[23:0], 1'b0};
			end
			// y >= 0 turns clockwise
			if (cnt_q < 5'(CORDIC_STEPS)) begin
				if (cy_q >= 0) begin
					cx_q <= cx_q + ys;
					cy_q <= cy_q - xs;
					cz_q <= cz_q + atan_q20(cnt_q);
				end else begin
					cx_q <= cx_q - ys;
					cy_q <= cy_q + xs;
					cz_q <= cz_q - atan_q20(cnt_q);
				end
			end
		end
	end

	assign done     = done_q;
	assign distance = root_q;
	assign bearing  = zero_q ? 16'sd0 : 16'(z_rnd >>> 8);

endmodule
